### design/uvc_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validate/count package
// Payload types, byte class constants and counter limits shared by the block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package uvc_pkg;

   localparam int MAX_STRING_BYTES = 65536;

   // Counters saturate at the smaller of the string limit and their range
   localparam logic [16:0] CNT_LIMIT =
      17'((MAX_STRING_BYTES < 'h1FFFF) ? MAX_STRING_BYTES : 'h1FFFF);
   localparam logic [16:0] OFFSET_LIMIT = 17'h0FFFF;

   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;
   localparam logic [7:0] ASCII_TOP    = 8'h80;
   localparam logic [7:0] LEAD_MIN     = 8'hC2;
   localparam logic [7:0] LEAD_MAX     = 8'hF4;
   localparam logic [7:0] LEAD3_MIN    = 8'hE0;
   localparam logic [7:0] LEAD4_MIN    = 8'hF0;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] CONT_A0      = 8'hA0;
   localparam logic [7:0] CONT_90      = 8'h90;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic        valid_res;
      logic [16:0] char_count;
      logic [15:0] error_offset;
   } rsp_payload_type;

endpackage

### design/uvc_req_if.sv
// ----------------------------------------------------------------------------
// UTF-8 validate/count request channel
// Valid/ready channel carrying at most one string byte per request.
// ----------------------------------------------------------------------------
interface uvc_req_if;

   logic                     valid;
   logic                     ready;
   uvc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### design/uvc_rsp_if.sv
// ----------------------------------------------------------------------------
// UTF-8 validate/count response channel
// Valid/ready channel carrying one string verdict per response.
// ----------------------------------------------------------------------------
interface uvc_rsp_if;

   logic                     valid;
   logic                     ready;
   uvc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### design/utf8_validate_count.sv
// ----------------------------------------------------------------------------
// UTF-8 validator and character counter
// Checks a byte stream for well-formed UTF-8 and counts characters, giving
// one verdict per string (or per first error).
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_ch    in         valid/ready        data_byte, byte_present, last
//  rsp_ch    out        valid/ready        valid_res, char_count, error_offset
//  csr       in         csr_wr_en          csr_wr_data (zero_ends_string)
//
//  One request per cycle sustained while the response side is not stalled;
//  an accepted request is held in the input register, then decoded into the
//  response register. The response register decouples the sides: a stalled
//  response holds the decode stage, and the input register fills behind it
//  before req_ch.ready falls. Synchronous active-high reset clears all string
//  state and the mode.
// ----------------------------------------------------------------------------
module utf8_validate_count (
   input  logic        clock,
   input  logic        reset,
   uvc_req_if.sink     req_ch,
   uvc_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import uvc_pkg::*;

   // input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   // string state
   logic [1:0]      bytes_needed_ff,  bytes_needed_in;
   logic [7:0]      lead_byte_ff,     lead_byte_in;
   logic            first_cont_ff,    first_cont_in;
   logic [16:0]     byte_position_ff, byte_position_in;
   logic [15:0]     char_start_ff,    char_start_in;
   logic [16:0]     chars_seen_ff,    chars_seen_in;
   logic            discarding_ff,    discarding_in;
   logic            zero_ends_ff;
   // response register
   logic            out_valid_ff;
   rsp_payload_type out_data_ff,      out_data_in;

   logic            advance;
   logic            emit;
   logic            emit_ok;
   logic            bad;
   logic [7:0]      b;

   function automatic logic [16:0] sat_inc(input logic [16:0] v);
      return (v < CNT_LIMIT) ? v + 17'd1 : v;
   endfunction

   function automatic logic cont_ok(input logic [7:0] cb, input logic first,
                                    input logic [7:0] lead);
      logic ok;
      ok = ((cb & CONT_MASK) == CONT_TAG);
      if (first) begin
         if (lead == LEAD_E0 && cb <  CONT_A0) ok = 1'b0;
         if (lead == LEAD_ED && cb >= CONT_A0) ok = 1'b0;
         if (lead == LEAD_F0 && cb <  CONT_90) ok = 1'b0;
         if (lead == LEAD_F4 && cb >= CONT_90) ok = 1'b0;
      end
      return ok;
   endfunction

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;
   assign b = in_data_ff.data_byte;

   always_comb begin
      bytes_needed_in  = bytes_needed_ff;
      lead_byte_in     = lead_byte_ff;
      first_cont_in    = first_cont_ff;
      byte_position_in = byte_position_ff;
      char_start_in    = char_start_ff;
      chars_seen_in    = chars_seen_ff;
      discarding_in    = discarding_ff;
      emit    = 1'b0;
      emit_ok = 1'b0;
      bad     = 1'b0;

      if (in_data_ff.byte_present && !discarding_ff) begin
         if (bytes_needed_ff == 2'd0) begin
            if (b == ZERO_BYTE && zero_ends_ff) begin
               emit          = 1'b1;
               emit_ok       = 1'b1;
               discarding_in = 1'b1;
            end else begin
               char_start_in = (byte_position_ff < OFFSET_LIMIT) ?
                               byte_position_ff[15:0] : OFFSET_LIMIT[15:0];
               if (b < ASCII_TOP) begin
                  chars_seen_in = sat_inc(chars_seen_ff);
               end else if (b < LEAD_MIN || b > LEAD_MAX) begin
                  bad = 1'b1;
               end else begin
                  lead_byte_in    = b;
                  first_cont_in   = 1'b1;
                  bytes_needed_in = (b < LEAD3_MIN) ? 2'd1 :
                                    (b < LEAD4_MIN) ? 2'd2 : 2'd3;
               end
            end
         end else begin
            if (!cont_ok(b, first_cont_ff, lead_byte_ff)) begin
               bad = 1'b1;
            end else begin
               first_cont_in   = 1'b0;
               bytes_needed_in = bytes_needed_ff - 2'd1;
               if (bytes_needed_ff == 2'd1) chars_seen_in = sat_inc(chars_seen_ff);
            end
         end
         if (bad) begin
            emit          = 1'b1;
            discarding_in = 1'b1;
         end else if (!discarding_in) begin
            byte_position_in = sat_inc(byte_position_ff);
         end
      end

      // end of string: truncated sequence counts as an error at its lead
      if (in_data_ff.last && !discarding_in && !emit) begin
         emit    = 1'b1;
         emit_ok = (bytes_needed_in == 2'd0);
      end

      out_data_in.valid_res    = emit_ok;
      out_data_in.char_count   = chars_seen_in;
      out_data_in.error_offset = emit_ok ? 16'd0 : char_start_in;

      if (in_data_ff.last) begin
         bytes_needed_in  = '0;
         lead_byte_in     = '0;
         first_cont_in    = 1'b0;
         byte_position_in = '0;
         char_start_in    = '0;
         chars_seen_in    = '0;
         discarding_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         zero_ends_ff     <= 1'b0;
         bytes_needed_ff  <= '0;
         lead_byte_ff     <= '0;
         first_cont_ff    <= 1'b0;
         byte_position_ff <= '0;
         char_start_ff    <= '0;
         chars_seen_ff    <= '0;
         discarding_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) zero_ends_ff <= csr_wr_data;
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
            in_data_ff  <= req_ch.payload;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && emit;
            out_data_ff  <= out_data_in;
            if (in_valid_ff) begin
               bytes_needed_ff  <= bytes_needed_in;
               lead_byte_ff     <= lead_byte_in;
               first_cont_ff    <= first_cont_in;
               byte_position_ff <= byte_position_in;
               char_start_ff    <= char_start_in;
               chars_seen_ff    <= chars_seen_in;
               discarding_ff    <= discarding_in;
            end
         end
      end
   end

   // a pending first continuation implies a multi-byte character is open
   a_first_cont_open: assert property (@(posedge clock) disable iff (reset)
      first_cont_ff |-> bytes_needed_ff != 2'd0)
      else $error("first continuation pending with no bytes needed");

   a_chars_le_bytes: assert property (@(posedge clock) disable iff (reset)
      chars_seen_ff <= byte_position_ff && byte_position_ff <= CNT_LIMIT)
      else $error("character count exceeds byte position or limit");

   a_valid_no_offset: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.valid_res |-> out_data_ff.error_offset == 16'd0)
      else $error("valid verdict carries an error offset");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> $stable(chars_seen_ff) && $stable(discarding_ff))
      else $error("string state moved while the response was stalled");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 validate/count testbench
// Streams strings at most one byte per request through the validator, takes
// each verdict from the directed table or an in-bench UTF-8 checker and
// compares every response field. The run covers a directed table and random
// phases with sender gaps and receiver stalls, in both zero-terminator modes.
// ----------------------------------------------------------------------------
module tb_top;

   import uvc_pkg::*;

   localparam int          SETTLE_CYCLES = 6;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          PHASE_BYTES   = 250;

   typedef struct packed {
      logic        zmode;
      logic [7:0]  data;
      logic        present;
      logic        fin;
      logic        typed;
      logic        ok;
      logic [16:0] chars;
      logic [15:0] offs;
   } plan_row_type;

   // zmode, byte, present, last, typed, ok, chars, offset
   localparam plan_row_type PLAN [24] = '{
      // three characters up to the four-byte ceiling, closed by a bare end
      '{1'b0, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hDF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hF4, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h8F, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 17'd3, 16'd0},
      // zero is plain ASCII with the terminator off
      '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 17'd1, 16'd0},
      // overlong three-byte form, rest of string dropped
      '{1'b0, 8'hE0, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h9F, 1'b1, 1'b0, 1'b1, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 16'd0},
      // missing continuation on the final request, then a lead byte above F4
      '{1'b0, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 17'd1, 16'd1},
      '{1'b0, 8'hF5, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 16'd0},
      // truncated by the end of string
      '{1'b0, 8'hE2, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b0, 8'h82, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 16'd0},
      // zero terminator, trailing bytes dropped silently
      '{1'b1, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 17'd1, 16'd0},
      '{1'b1, 8'h80, 1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 16'd0},
      // zero where a continuation is due
      '{1'b1, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0},
      '{1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 16'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   uvc_req_if req_ch ();
   uvc_rsp_if rsp_ch ();

   utf8_validate_count dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // checker state, mirrors the block's string state
   logic        zero_ends = 1'b0;
   logic [1:0]  cont_due;
   logic [7:0]  cur_lead;
   logic        first_cont;
   logic [16:0] byte_pos;
   logic [15:0] char_lead_pos;
   logic [16:0] char_total;
   logic        dropping;

   rsp_payload_type verdicts [$];
   req_payload_type pending [$];
   int              mismatches = 0;
   int              items_sent;
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct = 0;
   int unsigned     cycle_count = 0;

   function automatic void clear_string();
      cont_due      = 2'd0;
      cur_lead      = 8'h00;
      first_cont    = 1'b0;
      byte_pos      = 17'd0;
      char_lead_pos = 16'd0;
      char_total    = 17'd0;
      dropping      = 1'b0;
   endfunction

   function automatic logic [16:0] bump(input logic [16:0] v);
      return (v < CNT_LIMIT) ? v + 17'd1 : v;
   endfunction

   function automatic bit cont_fits(input logic [7:0] b);
      if ((b & CONT_MASK) != CONT_TAG) return 1'b0;
      if (first_cont) begin
         if (cur_lead == LEAD_E0 && b < CONT_A0) return 1'b0;
         if (cur_lead == LEAD_ED && b >= CONT_A0) return 1'b0;
         if (cur_lead == LEAD_F0 && b < CONT_90) return 1'b0;
         if (cur_lead == LEAD_F4 && b >= CONT_90) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advances the checker by one request; returns 1 when a verdict is due.
   function automatic bit validate_byte(input req_payload_type p,
                                        output rsp_payload_type r);
      bit bad;
      bit got;
      bad = 1'b0;
      got = 1'b0;
      r   = '0;
      if (p.byte_present && !dropping) begin
         if (cont_due == 2'd0) begin
            if (p.data_byte == ZERO_BYTE && zero_ends) begin
               r = rsp_payload_type'{1'b1, char_total, 16'h0000};
               got = 1'b1;
               dropping = 1'b1;
            end else begin
               char_lead_pos = (byte_pos < OFFSET_LIMIT) ? byte_pos[15:0] : 16'hFFFF;
               if (p.data_byte < ASCII_TOP)
                  char_total = bump(char_total);
               else if (p.data_byte < LEAD_MIN || p.data_byte > LEAD_MAX)
                  bad = 1'b1;
               else begin
                  cur_lead   = p.data_byte;
                  first_cont = 1'b1;
                  cont_due   = (p.data_byte < LEAD3_MIN) ? 2'd1 :
                               (p.data_byte < LEAD4_MIN) ? 2'd2 : 2'd3;
               end
            end
         end else if (!cont_fits(p.data_byte)) begin
            bad = 1'b1;
         end else begin
            first_cont = 1'b0;
            cont_due   = cont_due - 2'd1;
            if (cont_due == 2'd0) char_total = bump(char_total);
         end
         if (bad) begin
            r = rsp_payload_type'{1'b0, char_total, char_lead_pos};
            got = 1'b1;
            dropping = 1'b1;
         end else if (!dropping) begin
            byte_pos = bump(byte_pos);
         end
      end
      if (p.last) begin
         if (!dropping && !got) begin
            r = rsp_payload_type'{cont_due == 2'd0, char_total,
                                  (cont_due == 2'd0) ? 16'h0000 : char_lead_pos};
            got = 1'b1;
         end
         clear_string();
      end
      return got;
   endfunction

   function automatic void flag_mismatch(input string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      pending.push_back(req_payload_type'{b, 1'b1, 1'b0});
   endfunction

   function automatic void add_cont(input int n);
      for (int k = 0; k < n; k++) add_byte(8'($urandom_range(8'h80, 8'hBF)));
   endfunction

   // Offers one request, optionally after a gap, and books its verdict once taken.
   task automatic send_request(input req_payload_type p, input bit typed,
                               input rsp_payload_type want);
      rsp_payload_type r;
      bit              due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      due = validate_byte(p, r);
      if (typed) verdicts.push_back(want);
      else if (due) verdicts.push_back(r);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      // a request with no verdict may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      zero_ends = m;
   endtask

   // Mostly well-formed strings with some corruption, plus pure noise.
   task automatic send_random_string();
      int         n_chars;
      logic [7:0] lead_b;
      pending.delete();
      if ($urandom_range(99) < 20) begin
         n_chars = $urandom_range(1, 6);
         for (int k = 0; k < n_chars; k++) add_byte(8'($urandom));
      end else begin
         n_chars = $urandom_range(0, 8);
         for (int k = 0; k < n_chars; k++) begin
            case ($urandom_range(0, 3))
               0: add_byte(8'($urandom_range(0, 127)));
               1: begin
                  add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                  add_cont(1);
               end
               2: begin
                  lead_b = 8'($urandom_range(8'hE0, 8'hEF));
                  add_byte(lead_b);
                  if (lead_b == LEAD_E0) add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                  else if (lead_b == LEAD_ED) add_byte(8'($urandom_range(8'h80, 8'h9F)));
                  else add_cont(1);
                  add_cont(1);
               end
               default: begin
                  lead_b = 8'($urandom_range(8'hF0, 8'hF4));
                  add_byte(lead_b);
                  if (lead_b == LEAD_F0) add_byte(8'($urandom_range(8'h90, 8'hBF)));
                  else if (lead_b == LEAD_F4) add_byte(8'($urandom_range(8'h80, 8'h8F)));
                  else add_cont(1);
                  add_cont(2);
               end
            endcase
         end
         if (pending.size() != 0 && $urandom_range(99) < 15)
            pending[$urandom_range(0, pending.size() - 1)].data_byte = 8'($urandom);
         if (pending.size() != 0 && $urandom_range(99) < 8) void'(pending.pop_back());
         if ($urandom_range(99) < 6)
            pending.insert($urandom_range(0, pending.size()),
                           req_payload_type'{ZERO_BYTE, 1'b1, 1'b0});
      end
      if ($urandom_range(99) < 8)
         pending.insert($urandom_range(0, pending.size()),
                        req_payload_type'{8'($urandom), 1'b0, 1'b0});
      if (pending.size() == 0 || $urandom_range(99) < 20)
         pending.push_back(req_payload_type'{8'($urandom), 1'b0, 1'b1});
      else
         pending[pending.size() - 1].last = 1'b1;
      foreach (pending[j]) send_request(pending[j], 1'b0, '0);
      items_sent += pending.size();
   endtask

   always @(posedge clock) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_verdicts
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.payload;
         if (verdicts.size() == 0) begin
            flag_mismatch($sformatf("unexpected response valid_res=%0d chars=%0d offset=%0d",
                                    got.valid_res, got.char_count, got.error_offset));
         end else begin
            want = verdicts.pop_front();
            if (got.valid_res !== want.valid_res)
               flag_mismatch($sformatf("valid_res exp %0d act %0d",
                                       want.valid_res, got.valid_res));
            if (got.char_count !== want.char_count)
               flag_mismatch($sformatf("char_count exp %0d act %0d",
                                       want.char_count, got.char_count));
            if (got.error_offset !== want.error_offset)
               flag_mismatch($sformatf("error_offset exp %0d act %0d",
                                       want.error_offset, got.error_offset));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      clear_string();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_mode(1'b0);

      for (int i = 0; i < $size(PLAN); i++) begin
         if (PLAN[i].zmode !== zero_ends) set_mode(PLAN[i].zmode);
         send_request(req_payload_type'{PLAN[i].data, PLAN[i].present, PLAN[i].fin},
                      PLAN[i].typed,
                      rsp_payload_type'{PLAN[i].ok, PLAN[i].chars, PLAN[i].offs});
      end

      for (int phase = 0; phase < 4; phase++) begin
         set_mode(phase[0]);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         items_sent = 0;
         while (items_sent < PHASE_BYTES) send_random_string();
      end

      req_ch.valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (mismatches == 0 && verdicts.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
design/uvc_pkg.sv
design/uvc_req_if.sv
design/uvc_rsp_if.sv
design/utf8_validate_count.sv
sim/tb_top.sv
